// ===== hdl/tpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types and constants for the touch press classifier.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CADDR_W = 2;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    // register indexes on the configuration port
    localparam logic [CADDR_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CADDR_W-1:0] REG_MEDIUM     = 2'd1;
    localparam logic [CADDR_W-1:0] REG_LONG       = 2'd2;
    localparam logic [CADDR_W-1:0] REG_TARE_DELAY = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd200;
    localparam logic [CFG_W-1:0] MEDIUM_RST     = 16'd500;
    localparam logic [CFG_W-1:0] LONG_RST       = 16'd5000;
    localparam logic [CFG_W-1:0] TARE_DELAY_RST = 16'd1500;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] medium_ms;
        logic [CFG_W-1:0] long_ms;
        logic [CFG_W-1:0] tare_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic              stable_level;
        logic [TIME_W-1:0] last_change_time;
        logic [TIME_W-1:0] press_start_time;
        logic              long_seen;
        logic              tare_pending;
        logic [TIME_W-1:0] tare_due_time;
    } t_state;

    typedef struct packed {
        logic tare_fire;
        logic wifi_toggle;
        logic status_toggle;
        logic tare_scheduled;
        logic pressed_level;
    } t_result;

endpackage

// ===== hdl/tpc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tpc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wen,
    input  logic [tpc_pkg::CADDR_W-1:0]  i_cfg_addr,
    input  logic [tpc_pkg::CFG_W-1:0]    i_cfg_wdata,
    output tpc_pkg::t_cfg                o_cfg
);

    tpc_pkg::t_cfg r_cfg;
    tpc_pkg::t_cfg n_cfg;

    // decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wen) begin
            case (i_cfg_addr)
                tpc_pkg::REG_DEBOUNCE:   n_cfg.debounce_ms   = i_cfg_wdata;
                tpc_pkg::REG_MEDIUM:     n_cfg.medium_ms     = i_cfg_wdata;
                tpc_pkg::REG_LONG:       n_cfg.long_ms       = i_cfg_wdata;
                tpc_pkg::REG_TARE_DELAY: n_cfg.tare_delay_ms = i_cfg_wdata;
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= tpc_pkg::DEBOUNCE_RST;
            r_cfg.medium_ms     <= tpc_pkg::MEDIUM_RST;
            r_cfg.long_ms       <= tpc_pkg::LONG_RST;
            r_cfg.tare_delay_ms <= tpc_pkg::TARE_DELAY_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/tpc_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_classify
// Single-sample logic: debounce, press length classification, hold
// detection and delayed tare, from the current state to the next.
// ----------------------------------------------------------------------------
module tpc_classify (
    input  tpc_pkg::t_cfg                i_cfg,
    input  tpc_pkg::t_state              i_state,
    input  logic                         i_touched,
    input  logic [tpc_pkg::TIME_W-1:0]   i_now_ms,
    output tpc_pkg::t_state              o_state,
    output tpc_pkg::t_result             o_result
);

    logic [tpc_pkg::TIME_W-1:0] since_change;
    logic [tpc_pkg::TIME_W-1:0] press_len;
    logic [tpc_pkg::TIME_W-1:0] hold_len;
    logic [tpc_pkg::TIME_W-1:0] due_time;
    logic                       change_ok;
    logic                       hold_fire;
    logic                       rel_tare;
    logic                       rel_status;
    logic                       rel_wifi;
    logic                       tare_fire;
    tpc_pkg::t_state            mid;

    assign since_change = i_now_ms - i_state.last_change_time;
    assign press_len    = i_now_ms - i_state.press_start_time;
    assign due_time     = i_now_ms + {{(tpc_pkg::TIME_W-tpc_pkg::CFG_W){1'b0}},
                                      i_cfg.tare_delay_ms};
    assign change_ok    = (i_touched != i_state.stable_level) &&
                          (since_change > {{(tpc_pkg::TIME_W-tpc_pkg::CFG_W){1'b0}},
                                           i_cfg.debounce_ms});

    // accepted level change and release classification
    always_comb begin
        mid        = i_state;
        rel_tare   = 1'b0;
        rel_status = 1'b0;
        rel_wifi   = 1'b0;
        if (change_ok) begin
            if (i_touched) begin
                mid.press_start_time = i_now_ms;
            end else if (!i_state.long_seen) begin
                if (press_len >= {16'd0, i_cfg.long_ms}) begin
                    rel_wifi = 1'b1;
                end else if (press_len >= {16'd0, i_cfg.medium_ms}) begin
                    rel_status = 1'b1;
                end else begin
                    rel_tare          = 1'b1;
                    mid.tare_pending  = 1'b1;
                    mid.tare_due_time = due_time;
                end
            end
            mid.long_seen        = 1'b0;
            mid.stable_level     = i_touched;
            mid.last_change_time = i_now_ms;
        end
    end

    // long hold on the raw level, against the updated press start
    assign hold_len  = i_now_ms - mid.press_start_time;
    assign hold_fire = i_touched && !mid.long_seen && (mid.press_start_time != '0) &&
                       (hold_len >= {16'd0, i_cfg.long_ms});

    // hold flag and delayed tare
    always_comb begin
        o_state   = mid;
        tare_fire = 1'b0;
        if (hold_fire) begin
            o_state.long_seen = 1'b1;
        end
        if (mid.tare_pending && (i_now_ms >= mid.tare_due_time)) begin
            o_state.tare_pending = 1'b0;
            tare_fire            = 1'b1;
        end
    end

    // result word, a hold fires the wireless toggle as a long release does
    assign o_result = '{tare_fire:      tare_fire,
                        wifi_toggle:    rel_wifi | hold_fire,
                        status_toggle:  rel_status,
                        tare_scheduled: rel_tare,
                        pressed_level:  mid.stable_level};

endmodule

// ===== hdl/touch_press_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_press_classifier
// Debounces a touch input and classifies presses by their length.
// ----------------------------------------------------------------------------
// Each input word is one sample of the touch level with its millisecond time
// stamp; each sample produces exactly one output word with the debounced
// level and event flags. A sample is registered on the input side, goes through
// the combinational classifier logic and lands in the output register; the block
// takes one word per cycle while the result side does not stall. Once both
// registers hold a word, a stall on the result side holds s_axis_tready low in
// the same cycle. The user must write configuration through the plain write port
// while no sample is in flight; the block itself does not enforce this.
module touch_press_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration port
    input  logic                              i_cfg_wen,
    input  logic [tpc_pkg::CADDR_W-1:0]       i_cfg_addr,
    input  logic [tpc_pkg::CFG_W-1:0]         i_cfg_wdata,
    // sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // touched, now_ms[31:0], pad
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata    // pressed_level, tare_scheduled,
                                                              // status_toggle, wifi_toggle,
                                                              // tare_fire, pad
);

    tpc_pkg::t_cfg              cfg;
    tpc_pkg::t_state            r_state;
    tpc_pkg::t_state            n_state;
    tpc_pkg::t_result           n_result;
    tpc_pkg::t_result           r_result;
    logic                       r_in_valid;
    logic                       r_touched;
    logic [tpc_pkg::TIME_W-1:0] r_now_ms;
    logic                       r_out_valid;
    logic                       advance;
    logic                       in_take;

    tpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tpc_classify u_classify (
        .i_cfg     (cfg),
        .i_state   (r_state),
        .i_touched (r_touched),
        .i_now_ms  (r_now_ms),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // handshake
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_touched <= s_axis_tdata[0];
            r_now_ms  <= s_axis_tdata[tpc_pkg::TIME_W:1];
        end
    end

    // classifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_result};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the touch press classifier.
// ----------------------------------------------------------------------------
// Drives touch samples into the sample stream and checks every result word.
// A directed table comes first: debounce edges, the short, medium and long
// releases, the long hold, time stamp wrap, a press at time zero, same-step
// tare and a tare reschedule. Random press sequences follow under several
// register settings, with zero and all-ones among them. Expected words come
// from a cycle-free model of the classifier kept in this file. The sample side
// idles and the result side stalls at random, alone or together by phase.
// ----------------------------------------------------------------------------
module tb;
    import tpc_pkg::*;

    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_WORDS = 200;
    localparam int unsigned IN_PAD_W    = IN_TDATA_W - TIME_W - 1;

    // result constants, bits from high to low:
    // tare_fire, wifi_toggle, status_toggle, tare_scheduled, pressed_level
    localparam t_result NO_EVENT      = 5'b00000;
    localparam t_result LEVEL_HIGH    = 5'b00001;
    localparam t_result SHORT_RELEASE = 5'b00010;
    localparam t_result TARE_NOW      = 5'b10000;

    typedef struct packed {
        logic              touched;
        logic [TIME_W-1:0] now_ms;
        logic              typed;
        t_result           want;
    } t_sample;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wen = 1'b0;
    logic [CADDR_W-1:0]     i_cfg_addr = '0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // touched, now_ms[31:0], pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // pressed_level, tare_scheduled,
                                                 // status_toggle, wifi_toggle,
                                                 // tare_fire, pad

    // classifier model: register copy and state
    t_cfg              cfg;
    t_state            st;
    t_result           flag_q[$];
    t_sample           sample_q[$];
    logic [TIME_W-1:0] stamp = 32'd4000;
    int unsigned       send_gap_pct = 0;
    int unsigned       stall_pct = 0;
    int unsigned       err_count = 0;
    int unsigned       result_count = 0;

    // directed table, expected words typed in only for the obvious rows
    t_sample directed_rows [26] = '{
        '{1'b0, 32'd0,         1'b1, NO_EVENT},      // idle after reset
        '{1'b1, 32'd100,       1'b1, NO_EVENT},      // touch inside debounce
        '{1'b1, 32'd1000,      1'b1, LEVEL_HIGH},    // touch accepted
        '{1'b0, 32'd1100,      1'b0, NO_EVENT},      // release bounce
        '{1'b0, 32'd1300,      1'b1, SHORT_RELEASE}, // short press
        '{1'b0, 32'd2800,      1'b1, TARE_NOW},      // tare due
        '{1'b1, 32'd3000,      1'b0, NO_EVENT},
        '{1'b0, 32'd3500,      1'b0, NO_EVENT},      // medium at threshold
        '{1'b1, 32'd3700,      1'b0, NO_EVENT},      // exactly debounce, rejected
        '{1'b1, 32'd3701,      1'b0, NO_EVENT},
        '{1'b1, 32'd8700,      1'b0, NO_EVENT},      // one short of long hold
        '{1'b1, 32'd8701,      1'b0, NO_EVENT},      // long hold fires
        '{1'b0, 32'd9500,      1'b0, NO_EVENT},      // release after hold
        '{1'b1, 32'd10000,     1'b0, NO_EVENT},
        '{1'b0, 32'd15000,     1'b0, NO_EVENT},      // long release
        '{1'b1, 32'hFFFF_FE00, 1'b0, NO_EVENT},
        '{1'b0, 32'hFFFF_FF00, 1'b0, NO_EVENT},      // due time wraps, fires at once
        '{1'b1, 32'd0,         1'b0, NO_EVENT},      // press at stamp zero
        '{1'b1, 32'd6000,      1'b0, NO_EVENT},      // hold check skipped
        '{1'b0, 32'hFFFF_FFFF, 1'b0, NO_EVENT},
        '{1'b1, 32'd1000,      1'b0, NO_EVENT},
        '{1'b0, 32'd1300,      1'b0, NO_EVENT},      // tare pending
        '{1'b1, 32'd1600,      1'b0, NO_EVENT},
        '{1'b0, 32'd1900,      1'b0, NO_EVENT},      // reschedule
        '{1'b0, 32'd2800,      1'b0, NO_EVENT},      // old due time, no fire
        '{1'b0, 32'd3400,      1'b0, NO_EVENT}
    };

    touch_press_classifier u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #400_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // debounce, press length classification, hold and tare timing
    function automatic t_result classify_sample(input logic touched,
                                                input logic [TIME_W-1:0] now_ms);
        t_result           r;
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] held;
        r = NO_EVENT;
        since_change = now_ms - st.last_change_time;
        if (touched != st.stable_level && since_change > TIME_W'(cfg.debounce_ms)) begin
            if (touched) begin
                st.press_start_time = now_ms;
                st.long_seen = 1'b0;
            end else begin
                held = now_ms - st.press_start_time;
                if (!st.long_seen) begin
                    if (held >= TIME_W'(cfg.long_ms)) begin
                        r.wifi_toggle = 1'b1;
                    end else if (held >= TIME_W'(cfg.medium_ms)) begin
                        r.status_toggle = 1'b1;
                    end else begin
                        r.tare_scheduled = 1'b1;
                        st.tare_pending = 1'b1;
                        st.tare_due_time = now_ms + TIME_W'(cfg.tare_delay_ms);
                    end
                end
                st.long_seen = 1'b0;
            end
            st.stable_level = touched;
            st.last_change_time = now_ms;
        end
        // long hold on the raw level, once per press
        if (touched && !st.long_seen && st.press_start_time != '0) begin
            held = now_ms - st.press_start_time;
            if (held >= TIME_W'(cfg.long_ms)) begin
                st.long_seen = 1'b1;
                r.wifi_toggle = 1'b1;
            end
        end
        if (st.tare_pending && now_ms >= st.tare_due_time) begin
            st.tare_pending = 1'b0;
            r.tare_fire = 1'b1;
        end
        r.pressed_level = st.stable_level;
        return r;
    endfunction

    function automatic void add_sample(input logic touched, input logic [TIME_W-1:0] now_ms);
        sample_q.push_back('{touched, now_ms, 1'b0, NO_EVENT});
    endfunction

    // one press with bounce, hold samples and an optional wait for the tare
    task automatic queue_press();
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] hold_len;
        int unsigned       deb;
        int unsigned       k;
        deb = 32'(cfg.debounce_ms);
        k = $urandom_range(0, 11);
        if (k == 0) begin
            // noise anywhere in the time range
            stamp = $urandom;
            add_sample(1'($urandom), stamp);
        end else if (k == 1) begin
            stamp = 32'hFFFF_FFFF - $urandom_range(0, 6000);
        end
        case ($urandom_range(0, 3))
            0:       start = stamp + deb;
            1:       start = stamp + deb + 1;
            default: start = stamp + deb + $urandom_range(1, 300);
        endcase
        if (k == 2) begin
            start = '0;
        end
        add_sample(1'b1, start);
        repeat ($urandom_range(0, 2)) add_sample(1'($urandom), start + $urandom_range(0, deb));
        case ($urandom_range(0, 5))
            0:       hold_len = 32'(cfg.medium_ms) + $urandom_range(0, 2) - 1;
            1:       hold_len = 32'(cfg.long_ms) + $urandom_range(0, 2) - 1;
            2:       hold_len = $urandom_range(0, 32'(cfg.medium_ms));
            3:       hold_len = $urandom_range(0, 32'(cfg.long_ms) + 1000);
            4:       hold_len = deb + $urandom_range(0, 2);
            default: hold_len = $urandom_range(0, 300);
        endcase
        repeat ($urandom_range(0, 3)) add_sample(1'b1, start + $urandom_range(0, hold_len));
        if ($urandom_range(0, 2) == 0) begin
            add_sample(1'b1, start + 32'(cfg.long_ms));
        end
        stamp = start + hold_len;
        add_sample(1'b0, stamp);
        if ($urandom_range(0, 3) == 0) begin
            add_sample(1'($urandom), stamp + $urandom_range(0, deb));
        end
        // run up to the tare due time
        if ($urandom_range(0, 1) == 0) begin
            stamp = stamp + 32'(cfg.tare_delay_ms) + $urandom_range(0, 2) - 1;
            add_sample(1'b0, stamp);
        end
    endtask

    // one sample word through the handshake, then its expected result
    task automatic send_sample(input t_sample row);
        t_result want;
        while (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{IN_PAD_W{1'b0}}, row.now_ms, row.touched};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = classify_sample(row.touched, row.now_ms);
        if (row.typed) begin
            want = row.want;
        end
        flag_q.push_back(want);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (flag_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CADDR_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            REG_DEBOUNCE: cfg.debounce_ms   = value;
            REG_MEDIUM:   cfg.medium_ms     = value;
            REG_LONG:     cfg.long_ms       = value;
            default:      cfg.tare_delay_ms = value;
        endcase
    endtask

    // register setting per phase: zeros, all ones, medium above long, random
    task automatic load_config(input int unsigned phase);
        t_cfg setting;
        case (phase)
            1: setting = '0;
            2: setting = '1;
            3: begin
                setting.debounce_ms   = 16'($urandom_range(0, 300));
                setting.medium_ms     = 16'($urandom_range(2000, 4000));
                setting.long_ms       = 16'($urandom_range(500, 1999));
                setting.tare_delay_ms = 16'($urandom_range(0, 3000));
            end
            default: begin
                setting.debounce_ms   = 16'($urandom_range(0, 400));
                setting.medium_ms     = 16'($urandom_range(0, 3000));
                setting.long_ms       = 16'($urandom_range(0, 9000));
                setting.tare_delay_ms = 16'($urandom_range(0, 4000));
            end
        endcase
        write_reg(REG_DEBOUNCE, setting.debounce_ms);
        write_reg(REG_MEDIUM, setting.medium_ms);
        write_reg(REG_LONG, setting.long_ms);
        write_reg(REG_TARE_DELAY, setting.tare_delay_ms);
        i_cfg_wen <= 1'b0;
    endtask

    // result side stalls
    always @(posedge i_clk) begin
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(1, 100) > stall_pct);
    end

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d: %s is %b, expected %b",
                                      result_count, name, got, want));
        end
    endtask

    // result word check against the oldest expectation
    always @(posedge i_clk) begin : p_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[4:0]);
            if (flag_q.size() == 0) begin
                report_mismatch($sformatf("result %0d: word %b with nothing expected",
                                          result_count, m_axis_tdata));
            end else begin
                want = flag_q.pop_front();
                check_field("pressed_level", got.pressed_level, want.pressed_level);
                check_field("tare_scheduled", got.tare_scheduled, want.tare_scheduled);
                check_field("status_toggle", got.status_toggle, want.status_toggle);
                check_field("wifi_toggle", got.wifi_toggle, want.wifi_toggle);
                check_field("tare_fire", got.tare_fire, want.tare_fire);
            end
            result_count++;
        end
    end

    // main sequence
    initial begin : p_main
        int unsigned phase;
        int unsigned sent;
        cfg = '{DEBOUNCE_RST, MEDIUM_RST, LONG_RST, TARE_DELAY_RST};
        st  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[i]) sample_q.push_back(directed_rows[i]);
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain_results();
                load_config(phase);
            end
            case (phase % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 73; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 73; end
                default: begin send_gap_pct = 21; stall_pct = 21; end
            endcase
            while (sample_q.size() < PHASE_WORDS) queue_press();
            sent = 0;
            while (sample_q.size() != 0) begin
                // hold off once mid-phase until the pipe is empty
                if (phase == 1 && sent == PHASE_WORDS / 2) begin
                    drain_results();
                end
                send_sample(sample_q.pop_front());
                sent++;
            end
        end
        drain_results();
        repeat (6) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
